### hw/rtl/ptlru_pkg.sv
package ptlru_pkg;

    // Field widths of the request and response words
    localparam int ADDR_W      = 12;
    localparam int OFFSET_BITS = 7;
    localparam int RAW_PAGE_W  = ADDR_W - OFFSET_BITS;
    localparam int PHYS_W      = 10;
    localparam int OUTCOME_W   = 2;
    localparam int EVICT_W     = 5;

    // Recency counter width
    localparam int TICK_W = 32;

    // Default table sizes
    localparam int PAGE_COUNT  = 32;
    localparam int FRAME_COUNT = 8;

    // Outcome codes
    localparam logic [OUTCOME_W-1:0] OUTCOME_HIT   = 2'd0;
    localparam logic [OUTCOME_W-1:0] OUTCOME_FILL  = 2'd1;
    localparam logic [OUTCOME_W-1:0] OUTCOME_EVICT = 2'd2;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic clr_step;
        logic sel_in;
        logic accept;
        logic take_hit;
        logic scan_start;
        logic take_sel;
        logic evict;
        logic fill;
        logic lu_wr;
        logic out_load;
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic clr_last;
        logic pt_valid;
        logic scan_done;
        logic free_found;
        logic out_free;
    } t_status;

endpackage

### hw/rtl/ptlru_if.sv
// Request channel: one logical address per word
interface ptlru_req_if;
    logic                          valid;
    logic                          ready;
    logic [ptlru_pkg::ADDR_W-1:0]  logical_addr;

    modport source (output valid, output logical_addr, input ready);
    modport sink   (input valid, input logical_addr, output ready);
endinterface

// Response channel: one translation result per word
interface ptlru_rsp_if;
    logic                            valid;
    logic                            ready;
    logic [ptlru_pkg::PHYS_W-1:0]    physical_addr;
    logic [ptlru_pkg::OUTCOME_W-1:0] outcome;
    logic [ptlru_pkg::EVICT_W-1:0]   evicted_page;

    modport source (output valid, output physical_addr, output outcome,
                    output evicted_page, input ready);
    modport sink   (input valid, input physical_addr, input outcome,
                    input evicted_page, output ready);
endinterface

### hw/rtl/ptlru_datapath.sv
module ptlru_datapath #(
    parameter int PAGE_COUNT  = ptlru_pkg::PAGE_COUNT,
    parameter int FRAME_COUNT = ptlru_pkg::FRAME_COUNT
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  ptlru_pkg::t_cmd                 i_cmd,
    output ptlru_pkg::t_status              o_sts,
    input  logic [ptlru_pkg::ADDR_W-1:0]    i_logical_addr,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [ptlru_pkg::PHYS_W-1:0]    o_physical_addr,
    output logic [ptlru_pkg::OUTCOME_W-1:0] o_outcome,
    output logic [ptlru_pkg::EVICT_W-1:0]   o_evicted_page
);

    localparam int PG_W  = $clog2(PAGE_COUNT);
    localparam int FR_W  = $clog2(FRAME_COUNT);
    localparam int RAW_N = 1 << ptlru_pkg::RAW_PAGE_W;

    typedef struct packed {
        logic            valid;
        logic [FR_W-1:0] frame;
    } t_pte;

    // Page table, frame owners and last-use stamps
    t_pte                           r_pt_mem  [PAGE_COUNT];
    logic [PG_W-1:0]                r_own_mem [FRAME_COUNT];
    logic [ptlru_pkg::TICK_W-1:0]   r_lu_mem  [FRAME_COUNT];

    t_pte                           r_pt_q;
    logic [PG_W-1:0]                r_own_q;
    logic [ptlru_pkg::TICK_W-1:0]   r_lu_q;

    logic [PG_W-1:0]                r_clr_idx;
    logic [ptlru_pkg::TICK_W-1:0]   r_tick;
    logic [FRAME_COUNT-1:0]         r_used;
    logic [PG_W-1:0]                r_page;
    logic [ptlru_pkg::OFFSET_BITS-1:0] r_offset;
    logic [FR_W-1:0]                r_frame;
    logic [ptlru_pkg::OUTCOME_W-1:0] r_outcome;
    logic [PG_W-1:0]                r_evict;

    logic                           r_scan_run;
    logic [FR_W-1:0]                r_scan_idx;
    logic                           r_cmp_vld;
    logic [FR_W-1:0]                r_cmp_idx;
    logic                           r_free_found;
    logic [FR_W-1:0]                r_free_idx;
    logic [FR_W-1:0]                r_best_idx;
    logic [ptlru_pkg::TICK_W-1:0]   r_best_use;

    logic                           r_out_valid;
    logic [ptlru_pkg::PHYS_W-1:0]   r_out_phys;
    logic [ptlru_pkg::OUTCOME_W-1:0] r_out_outcome;
    logic [ptlru_pkg::EVICT_W-1:0]  r_out_evict;

    logic [PG_W-1:0]                w_mod_tab [RAW_N];
    logic [PG_W-1:0]                w_in_page;
    logic [PG_W-1:0]                w_pt_raddr;
    logic                           w_pt_we;
    logic [PG_W-1:0]                w_pt_waddr;
    t_pte                           w_pt_wdata;
    logic                           w_take_free;
    logic                           w_take_best;

    // Fold the raw page number onto the table size
    for (genvar v = 0; v < RAW_N; v++) begin : g_mod
        localparam int unsigned PAGE_MOD = v % PAGE_COUNT;
        assign w_mod_tab[v] = PG_W'(PAGE_MOD);
    end

    assign w_in_page = w_mod_tab[i_logical_addr[ptlru_pkg::ADDR_W-1:ptlru_pkg::OFFSET_BITS]];

    // Look up the incoming page while idle, the held page otherwise
    assign w_pt_raddr = i_cmd.sel_in ? w_in_page : r_page;

    // Page table write port: clear, invalidate the victim's page, or fill
    always_comb begin
        w_pt_we    = i_cmd.clr_step | i_cmd.evict | i_cmd.fill;
        w_pt_waddr = r_page;
        w_pt_wdata = '{valid: 1'b1, frame: r_frame};
        if (i_cmd.clr_step) begin
            w_pt_waddr = r_clr_idx;
            w_pt_wdata = '0;
        end else if (i_cmd.evict) begin
            w_pt_waddr = r_own_q;
            w_pt_wdata = '0;
        end
    end

    // Scan compare: first free frame and oldest stamp, ties to the lower index
    assign w_take_free = r_cmp_vld && !r_free_found && !r_used[r_cmp_idx];
    assign w_take_best = r_cmp_vld && ((r_cmp_idx == FR_W'(1)) || (r_lu_q < r_best_use));

    // Memories
    always_ff @(posedge i_clk) begin
        if (w_pt_we) begin
            r_pt_mem[w_pt_waddr] <= w_pt_wdata;
        end
        r_pt_q <= r_pt_mem[w_pt_raddr];

        if (i_cmd.fill) begin
            r_own_mem[r_frame] <= r_page;
        end
        r_own_q <= r_own_mem[r_best_idx];

        if (i_cmd.lu_wr) begin
            r_lu_mem[r_frame] <= r_tick;
        end
        r_lu_q <= r_lu_mem[r_scan_idx];
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_idx    <= '0;
            r_tick       <= '0;
            r_used       <= FRAME_COUNT'(1);
            r_scan_run   <= 1'b0;
            r_scan_idx   <= '0;
            r_cmp_vld    <= 1'b0;
            r_cmp_idx    <= '0;
            r_free_found <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.clr_step) begin
                r_clr_idx <= r_clr_idx + 1'b1;
            end
            // Advance the recency tick, saturating
            if (i_cmd.accept && (r_tick != '1)) begin
                r_tick <= r_tick + 1'b1;
            end
            if (i_cmd.fill) begin
                r_used[r_frame] <= 1'b1;
            end
            // Walk frames one to the last, one read a cycle
            if (i_cmd.scan_start) begin
                r_scan_run <= 1'b1;
                r_scan_idx <= FR_W'(1);
            end else if (r_scan_run) begin
                if (r_scan_idx == FR_W'(FRAME_COUNT - 1)) begin
                    r_scan_run <= 1'b0;
                end else begin
                    r_scan_idx <= r_scan_idx + 1'b1;
                end
            end
            r_cmp_vld <= r_scan_run;
            r_cmp_idx <= r_scan_idx;
            if (i_cmd.scan_start) begin
                r_free_found <= 1'b0;
            end else if (w_take_free) begin
                r_free_found <= 1'b1;
            end
            // Hold the result word until taken
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_page   <= w_in_page;
            r_offset <= i_logical_addr[ptlru_pkg::OFFSET_BITS-1:0];
        end
        if (w_take_free) begin
            r_free_idx <= r_cmp_idx;
        end
        if (w_take_best) begin
            r_best_idx <= r_cmp_idx;
            r_best_use <= r_lu_q;
        end
        if (i_cmd.take_hit) begin
            r_frame   <= r_pt_q.frame;
            r_outcome <= ptlru_pkg::OUTCOME_HIT;
            r_evict   <= '0;
        end
        if (i_cmd.take_sel) begin
            r_frame   <= r_free_found ? r_free_idx : r_best_idx;
            r_outcome <= r_free_found ? ptlru_pkg::OUTCOME_FILL : ptlru_pkg::OUTCOME_EVICT;
            r_evict   <= '0;
        end
        if (i_cmd.evict) begin
            r_evict <= r_own_q;
        end
        if (i_cmd.out_load) begin
            r_out_phys    <= ptlru_pkg::PHYS_W'({r_frame, r_offset});
            r_out_outcome <= r_outcome;
            r_out_evict   <= ptlru_pkg::EVICT_W'(r_evict);
        end
    end

    assign o_sts.clr_last   = (r_clr_idx == PG_W'(PAGE_COUNT - 1));
    assign o_sts.pt_valid   = r_pt_q.valid;
    assign o_sts.scan_done  = r_cmp_vld && (r_cmp_idx == FR_W'(FRAME_COUNT - 1));
    assign o_sts.free_found = r_free_found;
    assign o_sts.out_free   = !r_out_valid || i_out_ready;

    assign o_out_valid     = r_out_valid;
    assign o_physical_addr = r_out_phys;
    assign o_outcome       = r_out_outcome;
    assign o_evicted_page  = r_out_evict;

    // Frame zero is reserved and never filled
    a_fill_not_reserved: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.fill |-> (r_frame != '0))
        else $error("fill targets reserved frame");

    // A fill without eviction lands in a frame not yet in use
    a_fill_free_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.fill |-> (!r_used[r_frame] || (r_outcome == ptlru_pkg::OUTCOME_EVICT)))
        else $error("fill overwrites a used frame without eviction");

    // A hit maps to a frame already handed out
    a_hit_used_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.take_hit |-> ((r_pt_q.frame != '0) && r_used[r_pt_q.frame]))
        else $error("hit on a frame that is not in use");

endmodule

### hw/rtl/ptlru_ctrl.sv
module ptlru_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  ptlru_pkg::t_status i_sts,
    output ptlru_pkg::t_cmd    o_cmd
);

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CHECK,
        ST_HIT,
        ST_SCAN,
        ST_SELECT,
        ST_EVICT,
        ST_FILL,
        ST_OUT
    } t_state;

    t_state r_state;
    t_state n_state;

    // Decode commands and next state
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_cmd.sel_in = 1'b1;
                o_in_ready   = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (i_sts.pt_valid) begin
                    o_cmd.take_hit = 1'b1;
                    n_state        = ST_HIT;
                end else begin
                    o_cmd.scan_start = 1'b1;
                    n_state          = ST_SCAN;
                end
            end
            ST_HIT: begin
                o_cmd.lu_wr = 1'b1;
                n_state     = ST_OUT;
            end
            ST_SCAN: begin
                if (i_sts.scan_done) begin
                    n_state = ST_SELECT;
                end
            end
            ST_SELECT: begin
                o_cmd.take_sel = 1'b1;
                n_state        = i_sts.free_found ? ST_FILL : ST_EVICT;
            end
            ST_EVICT: begin
                o_cmd.evict = 1'b1;
                n_state     = ST_FILL;
            end
            ST_FILL: begin
                o_cmd.fill  = 1'b1;
                o_cmd.lu_wr = 1'b1;
                n_state     = ST_OUT;
            end
            ST_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // A finished scan is always followed by the frame choice
    a_scan_to_select: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_SCAN) && i_sts.scan_done) |=> (r_state == ST_SELECT))
        else $error("scan result not consumed");

endmodule

### hw/rtl/page_translate_lru.sv
// Channel   Dir  Word fields                                  Handshake
// i_req     in   logical_addr[11:0]                           valid/ready
// o_rsp     out  physical_addr[9:0] outcome[1:0] evicted_page  valid/ready
//
// A hit updates the frame's stamp and loads the result; a miss runs the
// last-use scan, which reads one frame per cycle from the stamp memory,
// then takes a free frame or evicts the oldest one, and fills it.
// After reset the page table is cleared; i_req.ready stays low meanwhile.
// One word is handled at a time; the result register holds a word for
// the sink while the next request is taken.
module page_translate_lru #(
    parameter int PAGE_COUNT  = ptlru_pkg::PAGE_COUNT,
    parameter int FRAME_COUNT = ptlru_pkg::FRAME_COUNT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ptlru_req_if.sink   i_req,
    ptlru_rsp_if.source o_rsp
);

    ptlru_pkg::t_cmd    w_cmd;
    ptlru_pkg::t_status w_sts;
    logic               w_in_ready;

    assign i_req.ready = w_in_ready;

    // Sequence the lookup, scan and fill
    ptlru_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (w_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // Tables, scan and result register
    ptlru_datapath #(
        .PAGE_COUNT  (PAGE_COUNT),
        .FRAME_COUNT (FRAME_COUNT)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_logical_addr  (i_req.logical_addr),
        .o_out_valid     (o_rsp.valid),
        .i_out_ready     (o_rsp.ready),
        .o_physical_addr (o_rsp.physical_addr),
        .o_outcome       (o_rsp.outcome),
        .o_evicted_page  (o_rsp.evicted_page)
    );

endmodule

### tb/tb_page_translate_lru.sv
`timescale 1ns / 100ps

// Expected translation of one request word
typedef struct {
    logic [ptlru_pkg::PHYS_W-1:0]    phys;
    logic [ptlru_pkg::OUTCOME_W-1:0] outcome;
    logic [ptlru_pkg::EVICT_W-1:0]   evicted;
} t_xlat_word;

class translation_scoreboard;
    localparam int PAGE_W  = $clog2(ptlru_pkg::PAGE_COUNT);
    localparam int FRAME_W = $clog2(ptlru_pkg::FRAME_COUNT);

    // Mirror of the page table and frame bookkeeping
    bit                              pt_valid [ptlru_pkg::PAGE_COUNT];
    logic [FRAME_W-1:0]              pt_frame [ptlru_pkg::PAGE_COUNT];
    logic [PAGE_W-1:0]               frame_page [ptlru_pkg::FRAME_COUNT];
    bit                              frame_taken [ptlru_pkg::FRAME_COUNT];
    logic [ptlru_pkg::TICK_W-1:0]    frame_stamp [ptlru_pkg::FRAME_COUNT];
    logic [ptlru_pkg::TICK_W-1:0]    tick;

    t_xlat_word expected_q[$];
    int n_requests;
    int n_checked;
    int n_hit;
    int n_fill;
    int n_evict;
    int n_errors;

    function new();
        foreach (pt_valid[p]) begin
            pt_valid[p] = 0;
            pt_frame[p] = '0;
        end
        foreach (frame_taken[f]) begin
            frame_taken[f] = (f == 0);
            frame_page[f]  = '0;
            frame_stamp[f] = '0;
        end
        tick = '0;
        n_requests = 0;
        n_checked  = 0;
        n_hit      = 0;
        n_fill     = 0;
        n_evict    = 0;
        n_errors   = 0;
    endfunction

    // Translate one accepted address and queue the expected response word
    function void note_request(logic [ptlru_pkg::ADDR_W-1:0] addr);
        logic [PAGE_W-1:0]                page;
        logic [ptlru_pkg::OFFSET_BITS-1:0] offset;
        logic [FRAME_W-1:0]               frame;
        logic [FRAME_W-1:0]               oldest;
        logic [PAGE_W-1:0]                victim;
        t_xlat_word                       w;

        page      = addr[ptlru_pkg::ADDR_W-1:ptlru_pkg::OFFSET_BITS];
        offset    = addr[ptlru_pkg::OFFSET_BITS-1:0];
        w.evicted = '0;
        n_requests++;

        // saturating recency tick
        if (tick != '1)
            tick++;

        if (pt_valid[page]) begin
            frame     = pt_frame[page];
            w.outcome = ptlru_pkg::OUTCOME_HIT;
            n_hit++;
        end else begin
            // lowest free frame above zero
            frame = '0;
            for (int f = 1; f < ptlru_pkg::FRAME_COUNT; f++)
                if (!frame_taken[f] && frame == 0)
                    frame = FRAME_W'(f);
            if (frame != 0) begin
                frame_taken[frame] = 1;
                w.outcome = ptlru_pkg::OUTCOME_FILL;
                n_fill++;
            end else begin
                // least recent frame, ties to the lowest index
                oldest = FRAME_W'(1);
                for (int f = 2; f < ptlru_pkg::FRAME_COUNT; f++)
                    if (frame_stamp[f] < frame_stamp[oldest])
                        oldest = FRAME_W'(f);
                frame            = oldest;
                victim           = frame_page[frame];
                pt_valid[victim] = 0;
                w.evicted        = victim;
                w.outcome        = ptlru_pkg::OUTCOME_EVICT;
                n_evict++;
            end
            pt_valid[page]    = 1;
            pt_frame[page]    = frame;
            frame_page[frame] = page;
        end
        frame_stamp[frame] = tick;
        w.phys = {frame, offset};
        expected_q.push_back(w);
    endfunction

    // Compare one response word with the oldest expectation
    function void check_response(logic [ptlru_pkg::PHYS_W-1:0] phys,
                                 logic [ptlru_pkg::OUTCOME_W-1:0] outcome,
                                 logic [ptlru_pkg::EVICT_W-1:0] evicted);
        t_xlat_word w;

        if (expected_q.size() == 0) begin
            n_errors++;
            if (n_errors <= 10)
                $display("ERROR: unexpected response phys=%h outcome=%0d evicted=%0d",
                         phys, outcome, evicted);
            return;
        end
        w = expected_q.pop_front();
        n_checked++;
        if (phys !== w.phys || outcome !== w.outcome || evicted !== w.evicted) begin
            n_errors++;
            if (n_errors <= 10)
                $display({"ERROR: response %0d: expected phys=%h outcome=%0d evicted=%0d,",
                          " got phys=%h outcome=%0d evicted=%0d"},
                         n_checked, w.phys, w.outcome, w.evicted, phys, outcome, evicted);
        end
    endfunction

    function int pending();
        return expected_q.size();
    endfunction
endclass

module tb_page_translate_lru;

    localparam int CHUNK_WORDS = 50;
    localparam int CHUNKS      = 25;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    bit   idle_on = 1'b0;

    ptlru_req_if req_if ();
    ptlru_rsp_if rsp_if ();

    translation_scoreboard xlat_sb = new();

    page_translate_lru dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    always #10 i_clk = ~i_clk;

    // Drive known values before reset is released
    initial begin
        req_if.valid        = 1'b0;
        req_if.logical_addr = '0;
        rsp_if.ready        = 1'b0;
    end

    // Hard stop if the run hangs
    initial begin
        #10ms;
        $display("Test completed with failures");
        $finish;
    end

    // Snoop both channels at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (req_if.valid && req_if.ready)
                xlat_sb.note_request(req_if.logical_addr);
            if (rsp_if.valid && rsp_if.ready)
                xlat_sb.check_response(rsp_if.physical_addr, rsp_if.outcome,
                                       rsp_if.evicted_page);
        end
    end

    // Stall the response side in random bursts while idling is enabled
    initial begin
        int stall;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (!idle_on || $urandom_range(0, 9) > 2) begin
                rsp_if.ready <= 1'b1;
            end else begin
                rsp_if.ready <= 1'b0;
                stall = $urandom_range(1, 9);
                repeat (stall - 1) @(negedge i_clk);
            end
        end
    end

    // Present one request word and hold it until accepted
    task automatic send_word(logic [ptlru_pkg::ADDR_W-1:0] addr);
        @(negedge i_clk);
        req_if.valid        <= 1'b1;
        req_if.logical_addr <= addr;
        do @(posedge i_clk); while (!req_if.ready);
    endtask

    // Drop valid for a burst of cycles
    task automatic hold_off(int cycles);
        @(negedge i_clk);
        req_if.valid <= 1'b0;
        repeat (cycles - 1) @(negedge i_clk);
    endtask

    // Send a word, maybe preceded by a random gap
    task automatic send_with_gap(logic [ptlru_pkg::ADDR_W-1:0] addr);
        if (idle_on && $urandom_range(0, 3) == 0)
            hold_off($urandom_range(1, 9));
        send_word(addr);
    endtask

    initial begin
        int base;
        int span;
        int page;
        int waited;
        int leftover;

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: fill every frame, hit, then evict including page zero
        send_word(12'h000);                 // page 0, lowest offset
        send_word(12'hFFF);                 // page 31, highest offset
        send_word(12'h07F);                 // hit page 0
        send_word(12'hF80);                 // hit page 31
        send_word({5'd1, 7'h55});
        send_word({5'd2, 7'h2A});
        send_word({5'd3, 7'h01});
        send_word({5'd4, 7'h40});
        send_word({5'd5, 7'h7E});           // last free frame
        send_word({5'd6, 7'h11});           // evicts page 0 (oldest frame)
        send_word({5'd0, 7'h22});           // page 0 back, evicts page 31
        send_word({5'd6, 7'h33});           // hit on a refilled frame
        send_word({5'd31, 7'h00});          // evict again
        send_word({5'd16, 7'h5A});
        send_word({5'd15, 7'h25});
        send_word({5'd3, 7'h7F});
        send_word({5'd8, 7'h00});

        // Random: working sets of shifting size with some full-range noise
        for (int c = 0; c < CHUNKS; c++) begin
            idle_on = (c < CHUNKS - 4) && (c % 3 != 2);
            base = $urandom_range(0, ptlru_pkg::PAGE_COUNT - 1);
            span = $urandom_range(3, 12);
            for (int i = 0; i < CHUNK_WORDS; i++) begin
                if ($urandom_range(0, 4) == 0) begin
                    send_with_gap(ptlru_pkg::ADDR_W'($urandom_range(0, 4095)));
                end else begin
                    page = (base + $urandom_range(0, span - 1)) % ptlru_pkg::PAGE_COUNT;
                    send_with_gap({page[4:0], 7'($urandom_range(0, 127))});
                end
            end
            // Let the block drain completely once
            if (c == 5) begin
                @(negedge i_clk);
                req_if.valid <= 1'b0;
                while (xlat_sb.pending() != 0) @(posedge i_clk);
            end
        end
        idle_on = 1'b0;
        @(negedge i_clk);
        req_if.valid <= 1'b0;

        // Wait for the remaining responses, then a short tail
        waited = 0;
        while (xlat_sb.pending() != 0 && waited < 2000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (30) @(posedge i_clk);
        leftover = xlat_sb.pending();
        if (leftover != 0)
            $display("ERROR: %0d responses never arrived", leftover);

        $display("Translated %0d addresses, %0d responses checked, %0d mismatches",
                 xlat_sb.n_requests, xlat_sb.n_checked, xlat_sb.n_errors);
        $display("Mix: %0d hits, %0d free-frame fills, %0d LRU evictions",
                 xlat_sb.n_hit, xlat_sb.n_fill, xlat_sb.n_evict);
        if (xlat_sb.n_errors == 0 && leftover == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
